### rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor package
// Shared constants, codes and types of the cursor glyph address engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

	localparam int COL_W  = 9;
	localparam int ROW_W  = 8;
	localparam int ADDR_W = 32;
	localparam int CLR_W  = 8;
	localparam int KIND_W = 2;

	localparam logic [COL_W:0] SCREEN_WIDTH  = 10'd320;
	localparam logic [ROW_W:0] SCREEN_HEIGHT = 9'd240;
	localparam logic [ROW_W:0] LINE_HEIGHT   = 9'd16;
	localparam logic [COL_W-1:0] WIDE_STEP   = 9'd16;
	localparam logic [COL_W-1:0] NARROW_STEP = 9'd8;

	localparam logic [KIND_W-1:0] CMD_NARROW = 2'd0;
	localparam logic [KIND_W-1:0] CMD_WIDE   = 2'd1;
	localparam logic [KIND_W-1:0] CMD_SCROLL = 2'd2;

	localparam logic [1:0] REG_HANZI_BASE = 2'd0;
	localparam logic [1:0] REG_ASCII_BASE = 2'd1;
	localparam logic [1:0] REG_TEXT_CLR   = 2'd2;
	localparam logic [1:0] REG_BACK_CLR   = 2'd3;

	localparam logic [ADDR_W-1:0] HANZI_BASE_RST = 32'h0001_0000;
	localparam logic [ADDR_W-1:0] ASCII_BASE_RST = 32'h0009_0000;
	localparam logic [CLR_W-1:0]  TEXT_CLR_RST   = 8'd255;
	localparam logic [CLR_W-1:0]  BACK_CLR_RST   = 8'd0;

	localparam logic [7:0] CHAR_LF      = 8'h0A;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] CHAR_BS      = 8'h08;
	localparam logic [7:0] NARROW_MAX   = 8'd128;
	localparam logic [7:0] GB_BIAS      = 8'hA0;
	localparam logic [ADDR_W-1:0] GB_ROW_LEN = 32'd94;
	localparam logic [ADDR_W-1:0] GB_ORIGIN  = 32'd95;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = 2;
	localparam int CNT_W      = 3;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             lead_waiting;
		logic [7:0]       lead_value;
	} cursor_t;

	typedef struct packed {
		logic [ADDR_W-1:0] hanzi_base;
		logic [ADDR_W-1:0] ascii_base;
		logic [CLR_W-1:0]  text_clr;
		logic [CLR_W-1:0]  back_clr;
	} config_t;

	typedef struct packed {
		logic             req_type;
		logic [7:0]       char_byte;
		logic [COL_W-1:0] start_x;
		logic [ROW_W-1:0] start_y;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] command_kind;
		logic [COL_W-1:0]  pos_x;
		logic [ROW_W-1:0]  pos_y;
		logic [ADDR_W-1:0] glyph_address;
		logic [CLR_W-1:0]  fore_colour;
		logic [CLR_W-1:0]  fill_colour;
		logic              last_of_run;
	} result_t;

endpackage

### rtl/tcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor step logic
// Computes the next cursor state and up to two commands for one request.
// ----------------------------------------------------------------------------
module tcc_step import tcc_pkg::*; (
	input  cursor_t        cur,
	input  config_t        cfg,
	input  item_t          item,
	output cursor_t        nxt,
	output logic [1:0]     res_count,
	output result_t        res_a,
	output result_t        res_b
);

	logic             is_wide;
	logic             is_narrow;
	logic             is_newline;
	logic             advance;
	logic             scroll;
	logic [ROW_W:0]   row_adv;
	logic [ROW_W-1:0] row_after;
	logic [COL_W-1:0] draw_col;
	logic [ROW_W-1:0] draw_row;
	logic [7:0]       gb_q;
	logic [7:0]       gb_w;
	logic [ADDR_W-1:0] gb_index;
	logic [ADDR_W-1:0] draw_addr;
	result_t          scroll_cmd;
	result_t          draw_cmd;

	always_comb begin
		is_wide    = !item.req_type && cur.lead_waiting;
		is_newline = !item.req_type && !cur.lead_waiting && item.char_byte == CHAR_LF;
		is_narrow  = !item.req_type && !cur.lead_waiting && item.char_byte != CHAR_LF
			&& item.char_byte != CHAR_CR && item.char_byte != CHAR_BS
			&& item.char_byte <= NARROW_MAX;
		advance    = is_newline
			|| ((is_wide || is_narrow) && {1'b0, cur.col} >= SCREEN_WIDTH);
		row_adv    = {1'b0, cur.row} + LINE_HEIGHT;
		scroll     = advance && row_adv >= SCREEN_HEIGHT;
		row_after  = scroll ? ROW_W'(SCREEN_HEIGHT - LINE_HEIGHT) : row_adv[ROW_W-1:0];
		draw_col   = advance ? '0 : cur.col;
		draw_row   = advance ? row_after : cur.row;

		gb_q      = cur.lead_value - GB_BIAS;
		gb_w      = item.char_byte - GB_BIAS;
		gb_index  = {24'd0, gb_q} * GB_ROW_LEN + {24'd0, gb_w} - GB_ORIGIN;
		draw_addr = is_wide ? cfg.hanzi_base + {gb_index[ADDR_W-6:0], 5'd0}
			: cfg.ascii_base + {20'd0, item.char_byte, 4'd0};

		scroll_cmd               = '0;
		scroll_cmd.command_kind  = CMD_SCROLL;
		scroll_cmd.fill_colour   = cfg.back_clr;

		draw_cmd.command_kind  = is_wide ? CMD_WIDE : CMD_NARROW;
		draw_cmd.pos_x         = draw_col;
		draw_cmd.pos_y         = draw_row;
		draw_cmd.glyph_address = draw_addr;
		draw_cmd.fore_colour   = cfg.text_clr;
		draw_cmd.fill_colour   = cfg.back_clr;
		draw_cmd.last_of_run   = 1'b1;

		res_count = {1'b0, scroll} + {1'b0, is_wide || is_narrow};
		res_a     = scroll ? scroll_cmd : draw_cmd;
		res_a.last_of_run = (res_count == 2'd1);
		res_b     = draw_cmd;

		nxt = cur;
		priority if (item.req_type) begin
			nxt.col          = item.start_x;
			nxt.row          = item.start_y;
			nxt.lead_waiting = 1'b0;
		end else if (is_wide || is_narrow) begin
			nxt.col          = draw_col + (is_wide ? WIDE_STEP : NARROW_STEP);
			nxt.row          = draw_row;
			nxt.lead_waiting = 1'b0;
		end else if (is_newline) begin
			nxt.col = '0;
			nxt.row = row_after;
		end else if (item.char_byte == CHAR_BS) begin
			if (cur.col < WIDE_STEP) begin
				nxt.col = '0;
				nxt.row = ({1'b0, cur.row} >= LINE_HEIGHT)
					? cur.row - ROW_W'(LINE_HEIGHT) : '0;
			end else begin
				nxt.col = cur.col - WIDE_STEP;
			end
		end else if (item.char_byte > NARROW_MAX) begin
			nxt.lead_waiting = 1'b1;
			nxt.lead_value   = item.char_byte;
		end
	end

endmodule

### rtl/tcc_out_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command output queue
// Four-entry queue that takes up to two commands per cycle and gives one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module tcc_out_fifo import tcc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_count,
	input  result_t    push_a,
	input  result_t    push_b,
	output logic       room,
	output logic       out_valid,
	input  logic       out_ready,
	output result_t    out_data
);

	result_t          entry_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= CNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_a;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_ptr_q + 1'b1] <= push_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push_count) - CNT_W'(pop);
		end
	end

endmodule

### rtl/text_console_cursor_glyph_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor glyph address engine
// Keeps the text cursor and turns string bytes into glyph draw commands.
// ----------------------------------------------------------------------------
// Each command is registered in the four-entry output queue, then sent to the master.
// Throughput: one request per cycle while the queue has room; a request that wraps
// into a scroll gives two commands; the queue drains one command per cycle while m_tready is high.
// Reset: cursor at the origin, no lead byte held, registers at their defaults,
// output queue empty.
module text_console_cursor_glyph_address import tcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_byte, start_x, start_y, zero fill
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // pos_x, pos_y, glyph_address, fore_colour,
	                               // fill_colour, zero fill
	output logic [1:0]  m_tuser,   // command_kind
	output logic        m_tlast,   // last_of_run
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cursor_t    cursor_q;
	cursor_t    cursor_nxt;
	config_t    cfg_q;
	item_t      item;
	logic       accept;
	logic [1:0] res_count;
	result_t    res_a;
	result_t    res_b;
	result_t    out_cmd;
	logic       room;

	assign item.req_type  = s_tuser;
	assign item.char_byte = s_tdata[7:0];
	assign item.start_x   = s_tdata[16:8];
	assign item.start_y   = s_tdata[24:17];

	assign s_tready = room;
	assign accept   = s_tvalid && room;

	tcc_step u_step (
		.cur       (cursor_q),
		.cfg       (cfg_q),
		.item      (item),
		.nxt       (cursor_nxt),
		.res_count (res_count),
		.res_a     (res_a),
		.res_b     (res_b)
	);

	tcc_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (accept ? res_count : 2'd0),
		.push_a     (res_a),
		.push_b     (res_b),
		.room       (room),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_cmd)
	);

	assign m_tdata = {7'd0, out_cmd.fill_colour, out_cmd.fore_colour,
		out_cmd.glyph_address, out_cmd.pos_y, out_cmd.pos_x};
	assign m_tuser = out_cmd.command_kind;
	assign m_tlast = out_cmd.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			cursor_q <= cursor_nxt;
		end
	end

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hanzi_base <= HANZI_BASE_RST;
			cfg_q.ascii_base <= ASCII_BASE_RST;
			cfg_q.text_clr   <= TEXT_CLR_RST;
			cfg_q.back_clr   <= BACK_CLR_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_HANZI_BASE: cfg_q.hanzi_base <= pwdata;
				REG_ASCII_BASE: cfg_q.ascii_base <= pwdata;
				REG_TEXT_CLR:   cfg_q.text_clr   <= pwdata[CLR_W-1:0];
				REG_BACK_CLR:   cfg_q.back_clr   <= pwdata[CLR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HANZI_BASE: prdata = cfg_q.hanzi_base;
			REG_ASCII_BASE: prdata = cfg_q.ascii_base;
			REG_TEXT_CLR:   prdata = {24'd0, cfg_q.text_clr};
			REG_BACK_CLR:   prdata = {24'd0, cfg_q.back_clr};
			default:        prdata = '0;
		endcase
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the text console cursor glyph address engine
// Streams character bytes and start requests into the engine with random gaps
// and output stalls, predicts every draw and scroll command from its own model
// of the cursor, and compares each command field by field. Registers are
// changed between bursts, and their values are read back.
// ----------------------------------------------------------------------------
module tb_top;
	import tcc_pkg::*;

	localparam int unsigned STALL_LIMIT        = 2000;
	localparam int unsigned DRAIN_CYCLES       = 4;
	localparam int unsigned LONG_HOLD          = 80;
	localparam logic [31:0] GLYPH_WIDE_BYTES   = 32'd32;
	localparam logic [31:0] GLYPH_NARROW_BYTES = 32'd16;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	text_console_cursor_glyph_address dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	// Cursor and register copies kept by the command predictor.
	int unsigned col_pos    = 0;
	int unsigned row_pos    = 0;
	bit          lead_held  = 1'b0;
	logic [7:0]  lead_byte  = '0;
	logic [31:0] hanzi_base = HANZI_BASE_RST;
	logic [31:0] ascii_base = ASCII_BASE_RST;
	logic [7:0]  text_clr   = TEXT_CLR_RST;
	logic [7:0]  back_clr   = BACK_CLR_RST;

	result_t     glyph_cmds[$];
	int unsigned errors       = 0;
	int unsigned requests_sent = 0;
	int unsigned narrow_seen  = 0;
	int unsigned wide_seen    = 0;
	int unsigned scroll_seen  = 0;
	int unsigned settings_used = 1;
	int unsigned idle_cycles  = 0;
	int unsigned hold_asks    = 0;
	int unsigned holds_done   = 0;
	int unsigned hold_left    = 0;
	bit          calm         = 1'b0;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic result_t make_cmd(logic [1:0] kind, int unsigned x, int unsigned y,
	                                     logic [31:0] addr);
		result_t r;
		r.command_kind  = kind;
		r.pos_x         = 9'(x);
		r.pos_y         = 8'(y);
		r.glyph_address = addr;
		r.fore_colour   = (kind == CMD_SCROLL) ? 8'd0 : text_clr;
		r.fill_colour   = back_clr;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic bit advance_line();
		row_pos += LINE_HEIGHT;
		if (row_pos >= SCREEN_HEIGHT) begin
			row_pos = SCREEN_HEIGHT - LINE_HEIGHT;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit wrap_column();
		if (col_pos >= SCREEN_WIDTH) begin
			col_pos = 0;
			return advance_line();
		end
		return 1'b0;
	endfunction

	function automatic void predict_commands(item_t req);
		result_t     pend[$];
		result_t     r;
		logic [7:0]  qb;
		logic [7:0]  wb;
		logic [31:0] q;
		logic [31:0] w;
		logic [31:0] off;
		logic [7:0]  ch;
		ch = req.char_byte;
		if (req.req_type) begin
			col_pos   = req.start_x;
			row_pos   = req.start_y;
			lead_held = 1'b0;
			return;
		end
		if (lead_held) begin
			qb  = lead_byte - GB_BIAS;
			wb  = ch - GB_BIAS;
			q   = {24'd0, qb};
			w   = {24'd0, wb};
			off = (GB_ROW_LEN * (q - 32'd1) + (w - 32'd1)) * GLYPH_WIDE_BYTES;
			lead_held = 1'b0;
			if (wrap_column())
				pend.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
			pend.push_back(make_cmd(CMD_WIDE, col_pos, row_pos, hanzi_base + off));
			col_pos += WIDE_STEP;
		end else if (ch == CHAR_LF) begin
			col_pos = 0;
			if (advance_line())
				pend.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
		end else if (ch == CHAR_CR) begin
		end else if (ch == CHAR_BS) begin
			if (col_pos < WIDE_STEP) begin
				col_pos = 0;
				row_pos = (row_pos >= LINE_HEIGHT) ? row_pos - LINE_HEIGHT : 0;
			end else begin
				col_pos -= WIDE_STEP;
			end
		end else if (ch <= NARROW_MAX) begin
			if (wrap_column())
				pend.push_back(make_cmd(CMD_SCROLL, 0, 0, '0));
			pend.push_back(make_cmd(CMD_NARROW, col_pos, row_pos,
			                        ascii_base + {24'd0, ch} * GLYPH_NARROW_BYTES));
			col_pos += NARROW_STEP;
		end else begin
			lead_held = 1'b1;
			lead_byte = ch;
		end
		foreach (pend[i]) begin
			r = pend[i];
			r.last_of_run = (i == pend.size() - 1);
			glyph_cmds.push_back(r);
		end
	endfunction

	function automatic logic [31:0] register_value(logic [1:0] idx);
		case (idx)
			REG_HANZI_BASE: return hanzi_base;
			REG_ASCII_BASE: return ascii_base;
			REG_TEXT_CLR:   return {24'd0, text_clr};
			default:        return {24'd0, back_clr};
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input bit is_start, input logic [7:0] ch,
	                            input logic [8:0] x, input logic [7:0] y);
		int unsigned gap;
		item_t       req;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.req_type  = is_start;
		req.char_byte = is_start ? 8'd0 : ch;
		req.start_x   = is_start ? x : 9'd0;
		req.start_y   = is_start ? y : 8'd0;
		s_tvalid <= 1'b1;
		s_tuser  <= req.req_type;
		s_tdata  <= {7'd0, req.start_y, req.start_x, req.char_byte};
		do @(posedge clk); while (!s_tready);
		predict_commands(req);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_char(input logic [7:0] ch);
		send_request(1'b0, ch, '0, '0);
	endtask

	task automatic send_start(input logic [8:0] x, input logic [7:0] y);
		send_request(1'b1, '0, x, y);
	endtask

	task automatic finish_burst();
		s_tvalid <= 1'b0;
		while (glyph_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_HANZI_BASE: hanzi_base = val;
			REG_ASCII_BASE: ascii_base = val;
			REG_TEXT_CLR:   text_clr   = val[7:0];
			default:        back_clr   = val[7:0];
		endcase
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("register readback", register_value(idx), prdata);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] hb, input logic [31:0] ab,
	                             input logic [31:0] tc, input logic [31:0] bc);
		finish_burst();
		write_register(REG_HANZI_BASE, hb);
		write_register(REG_ASCII_BASE, ab);
		write_register(REG_TEXT_CLR, tc);
		write_register(REG_BACK_CLR, bc);
		settings_used++;
	endtask

	task automatic send_gb_pair();
		send_char(8'($urandom_range(8'hA1, 8'hF7)));
		send_char(8'($urandom_range(8'hA1, 8'hFE)));
	endtask

	// Mostly well-formed text with lines, hanzi and cursor moves, plus noise.
	task automatic send_random_text(input int unsigned count);
		int unsigned sent;
		int unsigned r;
		sent = 0;
		while (sent < count) begin
			if (sent % 64 == 0)
				calm = ($urandom_range(0, 4) == 0);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_char(8'($urandom_range(8'h20, 8'h7E)));
			end else if (r < 68) begin
				send_gb_pair();
				sent++;
			end else if (r < 74) begin
				send_char(CHAR_LF);
			end else if (r < 77) begin
				send_char(CHAR_CR);
			end else if (r < 83) begin
				send_char(CHAR_BS);
			end else if (r < 88) begin
				send_start(9'($urandom_range(0, 39) * 8), 8'($urandom_range(0, 239)));
			end else if (r < 96) begin
				send_char(8'($urandom_range(0, 255)));
			end else begin
				send_start(9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
			end
			sent++;
		end
		calm = 1'b0;
	endtask

	task automatic test_directed_cases();
		send_start(9'd0, 8'd0);
		send_char(8'h41);
		send_char(8'h00);
		send_char(NARROW_MAX);
		send_char(8'hB0);
		send_char(8'hA1);
		send_char(8'hFF);
		send_char(8'hFF);
		send_char(8'h81);
		send_char(CHAR_LF);
		send_char(CHAR_CR);
		// A start request drops a held lead byte.
		send_char(8'hC0);
		send_start(9'd16, 8'd32);
		send_char(8'h61);
		send_char(CHAR_BS);
		send_char(CHAR_BS);
		send_char(CHAR_LF);
		send_start(9'd0, 8'd0);
		send_char(CHAR_BS);
		send_start(9'd319, 8'd224);
		send_char(8'h7E);
		send_char(8'h7A);
		send_char(CHAR_LF);
		send_start(9'd511, 8'd255);
		send_char(8'h71);
	endtask

	task automatic test_register_extremes();
		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 0)
				apply_setting('1, '1, '1, '1);
			else
				apply_setting('0, '0, '0, '0);
			send_char(8'h48);
			send_char(8'hA1);
			send_char(8'hA1);
			send_char(8'hA0);
			send_char(8'hA0);
			send_char(8'hFF);
			send_char(8'hFE);
			send_char(CHAR_LF);
			send_char(8'h7F);
			send_random_text(30);
		end
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 4; phase++) begin
			apply_setting($urandom, $urandom, $urandom, $urandom);
			send_random_text(200);
		end
	endtask

	task automatic test_output_backpressure();
		finish_burst();
		calm = 1'b1;
		hold_asks++;
		for (int i = 0; i < 40; i++) begin
			if (i % 8 == 7)
				send_gb_pair();
			else
				send_char(8'($urandom_range(8'h20, 8'h7E)));
		end
		calm = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (holds_done != hold_asks) begin
			holds_done = hold_asks;
			hold_left  = LONG_HOLD - 1;
			m_tready <= 1'b0;
		end else if (calm) begin
			m_tready <= 1'b1;
		end else begin
			hold_left = pick_gap();
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_commands
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (glyph_cmds.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected command, expected none, got kind %0d",
				         $time, m_tuser);
			end else begin
				want = glyph_cmds.pop_front();
				check_field("command_kind", want.command_kind, m_tuser);
				check_field("pos_x", want.pos_x, m_tdata[8:0]);
				check_field("pos_y", want.pos_y, m_tdata[16:9]);
				check_field("glyph_address", want.glyph_address, m_tdata[48:17]);
				check_field("fore_colour", want.fore_colour, m_tdata[56:49]);
				check_field("fill_colour", want.fill_colour, m_tdata[64:57]);
				check_field("last_of_run", want.last_of_run, m_tlast);
				case (want.command_kind)
					CMD_NARROW: narrow_seen++;
					CMD_WIDE:   wide_seen++;
					default:    scroll_seen++;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout after %0d cycles without progress.", idle_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_cases();
		test_register_extremes();
		test_random_settings();
		test_output_backpressure();
		finish_burst();
		$display("Sent %0d requests; checked %0d narrow, %0d wide and %0d scroll commands.",
		         requests_sent, narrow_seen, wide_seen, scroll_seen);
		$display("Used %0d register settings, extremes included, and one long output stall.",
		         settings_used);
		if (errors == 0 && glyph_cmds.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### files.f
rtl/tcc_pkg.sv
rtl/tcc_step.sv
rtl/tcc_out_fifo.sv
rtl/text_console_cursor_glyph_address.sv
bench/tb_top.sv
